// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the lens distortion mapper.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lens distortion mapper: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lens distortion mapper: assertion failed");

`endif

// File: rtl/ldm_pkg.sv
// Shared types and constants for the lens distortion mapper.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ldm_pkg;

    // Pipeline depth, from the input registers to the output register.
    localparam int NUM_STAGES = 10;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K1     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K2     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K3     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TANGENTIAL_P1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TANGENTIAL_P2 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_PACKED = 3'd7;

    // Focal length after reset: 1024.0 pixels in Q14.4.
    localparam logic [17:0] FOCAL_RESET = 18'd16384;

    // Saturation bounds of a pixel coordinate.
    localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] OUT_MIN = 20'sh80000;

    // Input word: one normalised point.
    typedef struct packed {
        logic signed [15:0] x_norm;
        logic signed [15:0] y_norm;
    } point_t;

    // Output word: one distorted pixel position.
    typedef struct packed {
        logic signed [19:0] pixel_u;
        logic signed [19:0] pixel_v;
        logic               clipped;
    } pixel_t;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic signed [19:0] k1;
        logic signed [19:0] k2;
        logic signed [19:0] k3;
        logic signed [19:0] p1;
        logic signed [19:0] p2;
        logic [17:0]        fx;
        logic [17:0]        fy;
        logic [15:0]        cx;
        logic [15:0]        cy;
    } ldm_cfg_t;

    // One load enable per pipeline stage.
    typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

// File: rtl/ldm_cfg_regs.sv
// Configuration register file of the lens distortion mapper.
// Depends on ldm_pkg for the register indexes and the register struct.
`default_nettype none

module ldm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ldm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ldm_pkg::ldm_cfg_t                cfg
);
    import ldm_pkg::*;

    ldm_cfg_t cfg_reg;
    ldm_cfg_t cfg_next;

    // Decode a write; bits above a register's width are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIAL_K1:     cfg_next.k1 = cfg_data[19:0];
                REG_RADIAL_K2:     cfg_next.k2 = cfg_data[19:0];
                REG_RADIAL_K3:     cfg_next.k3 = cfg_data[19:0];
                REG_TANGENTIAL_P1: cfg_next.p1 = cfg_data[19:0];
                REG_TANGENTIAL_P2: cfg_next.p2 = cfg_data[19:0];
                REG_FOCAL_X:       cfg_next.fx = cfg_data[17:0];
                REG_FOCAL_Y:       cfg_next.fy = cfg_data[17:0];
                REG_CENTER_PACKED:
                begin
                    cfg_next.cx = cfg_data[15:0];
                    cfg_next.cy = cfg_data[31:16];
                end
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= '0;
            cfg_reg.fx <= FOCAL_RESET;
            cfg_reg.fy <= FOCAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/ldm_geom.sv
// Front end of the pipeline: squares, cross product and radius squared.
// Depends on ldm_pkg for the input word and the stage enables.
`default_nettype none

module ldm_geom (
    input  logic                clk,
    input  ldm_pkg::point_t     point,
    input  ldm_pkg::stage_en_t  load,
    output logic [23:0]         r2s,
    output logic [32:0]         r2x,
    output logic [32:0]         r2y,
    output logic signed [31:0]  xy,
    output logic signed [15:0]  x,
    output logic signed [15:0]  y
);
    import ldm_pkg::*;

    logic signed [15:0] x1_reg;
    logic signed [15:0] y1_reg;
    logic signed [31:0] xx_reg;
    logic signed [31:0] yy_reg;
    logic signed [31:0] xy1_reg;

    logic [23:0]        r2s_reg;
    logic [32:0]        r2x_reg;
    logic [32:0]        r2y_reg;
    logic signed [31:0] xy2_reg;
    logic signed [15:0] x2_reg;
    logic signed [15:0] y2_reg;

    logic [32:0] r2_sum;

    // Stage 1: the three products of the coordinates.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            x1_reg  <= point.x_norm;
            y1_reg  <= point.y_norm;
            xx_reg  <= $signed(point.x_norm) * $signed(point.x_norm);
            yy_reg  <= $signed(point.y_norm) * $signed(point.y_norm);
            xy1_reg <= $signed(point.x_norm) * $signed(point.y_norm);
        end
    end

    // Both squares are non-negative, so they add as unsigned values.
    assign r2_sum = {1'b0, xx_reg} + {1'b0, yy_reg};

    // Stage 2: r2 in Q.20 and the sums feeding the tangential terms.
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            r2s_reg <= r2_sum[31:8];
            r2x_reg <= r2_sum + {xx_reg, 1'b0};
            r2y_reg <= r2_sum + {yy_reg, 1'b0};
            xy2_reg <= xy1_reg;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
        end
    end

    assign r2s = r2s_reg;
    assign r2x = r2x_reg;
    assign r2y = r2y_reg;
    assign xy  = xy2_reg;
    assign x   = x2_reg;
    assign y   = y2_reg;

endmodule

`default_nettype wire

// File: rtl/ldm_radial.sv
// Radial gain path: powers of r2 and the polynomial 1 + k1*r2 + k2*r4 + k3*r6.
// Depends on ldm_pkg for the register struct and the stage enables.
`default_nettype none

module ldm_radial (
    input  logic                clk,
    input  ldm_pkg::ldm_cfg_t   cfg,
    input  ldm_pkg::stage_en_t  load,
    input  logic [23:0]         r2s,
    output logic signed [35:0]  gain20
);
    import ldm_pkg::*;

    // One in Q.36.
    localparam logic signed [51:0] GAIN_ONE = 52'sh10_0000_0000;

    logic [47:0]        sq_reg;
    logic [23:0]        r2s3_reg;
    logic [50:0]        r6p_reg;
    logic signed [44:0] k1r2s_reg;
    logic signed [47:0] k2r4_reg;
    logic signed [50:0] k3r6_reg;
    logic signed [44:0] k1r2s5_reg;
    logic signed [47:0] k2r4_5_reg;
    logic signed [35:0] gain20_reg;

    logic [26:0]        r4;
    logic [29:0]        r6;
    logic signed [51:0] gain_sum;

    // Stage 3: r2 squared.
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            sq_reg   <= r2s * r2s;
            r2s3_reg <= r2s;
        end
    end

    assign r4 = sq_reg[46:20];

    // Stage 4: r6 product and the first two gain terms.
    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            r6p_reg   <= r4 * r2s3_reg;
            k1r2s_reg <= $signed(cfg.k1) * $signed({1'b0, r2s3_reg});
            k2r4_reg  <= $signed(cfg.k2) * $signed({1'b0, r4});
        end
    end

    assign r6 = r6p_reg[49:20];

    // Stage 5: third gain term.
    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            k3r6_reg   <= $signed(cfg.k3) * $signed({1'b0, r6});
            k1r2s5_reg <= k1r2s_reg;
            k2r4_5_reg <= k2r4_reg;
        end
    end

    assign gain_sum = GAIN_ONE + k1r2s5_reg + k2r4_5_reg + k3r6_reg;

    // Stage 6: gain summed in Q.36 and cut to Q.20, rounding down.
    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            gain20_reg <= gain_sum[51:16];
        end
    end

    assign gain20 = gain20_reg;

endmodule

`default_nettype wire

// File: rtl/ldm_tangential.sv
// Tangential path: p1 and p2 terms in Q.44, cut to Q.34 and delayed to meet the gain.
// Depends on ldm_pkg for the register struct and the stage enables.
`default_nettype none

module ldm_tangential (
    input  logic                clk,
    input  ldm_pkg::ldm_cfg_t   cfg,
    input  ldm_pkg::stage_en_t  load,
    input  logic signed [31:0]  xy,
    input  logic [32:0]         r2x,
    input  logic [32:0]         r2y,
    output logic signed [44:0]  tan_x,
    output logic signed [44:0]  tan_y
);
    import ldm_pkg::*;

    logic signed [51:0] p1xy_reg;
    logic signed [51:0] p2xy_reg;
    logic signed [53:0] p2r2x_reg;
    logic signed [53:0] p1r2y_reg;

    logic signed [44:0] tanx4_reg;
    logic signed [44:0] tany4_reg;
    logic signed [44:0] tanx5_reg;
    logic signed [44:0] tany5_reg;
    logic signed [44:0] tanx6_reg;
    logic signed [44:0] tany6_reg;
    logic signed [44:0] tanx7_reg;
    logic signed [44:0] tany7_reg;

    logic signed [54:0] tx_sum;
    logic signed [54:0] ty_sum;

    // Stage 3: coefficient products.
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            p1xy_reg  <= $signed(cfg.p1) * xy;
            p2xy_reg  <= $signed(cfg.p2) * xy;
            p2r2x_reg <= $signed(cfg.p2) * $signed({1'b0, r2x});
            p1r2y_reg <= $signed(cfg.p1) * $signed({1'b0, r2y});
        end
    end

    // The doubled cross terms are a one-place shift.
    assign tx_sum = $signed({p1xy_reg, 1'b0}) + p2r2x_reg;
    assign ty_sum = p1r2y_reg + $signed({p2xy_reg, 1'b0});

    // Stage 4: sums cut to Q.34, rounding down.
    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            tanx4_reg <= tx_sum[54:10];
            tany4_reg <= ty_sum[54:10];
        end
    end

    // Stages 5 to 7: hold the terms until the radial product is ready.
    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            tanx5_reg <= tanx4_reg;
            tany5_reg <= tany4_reg;
        end
        if (load[5])
        begin
            tanx6_reg <= tanx5_reg;
            tany6_reg <= tany5_reg;
        end
        if (load[6])
        begin
            tanx7_reg <= tanx6_reg;
            tany7_reg <= tany6_reg;
        end
    end

    assign tan_x = tanx7_reg;
    assign tan_y = tany7_reg;

endmodule

`default_nettype wire

// File: rtl/ldm_project.sv
// Back end: radial product, tangential sum, focal scaling, centre and saturation.
// Depends on ldm_pkg for the register struct, the output word and the bounds.
`default_nettype none

module ldm_project (
    input  logic                clk,
    input  ldm_pkg::ldm_cfg_t   cfg,
    input  ldm_pkg::stage_en_t  load,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    input  logic signed [35:0]  gain20,
    input  logic signed [44:0]  tan_x,
    input  logic signed [44:0]  tan_y,
    output ldm_pkg::pixel_t     pixel
);
    import ldm_pkg::*;

    // Half a Q.4 LSB, expressed in Q.24, for rounding to Q.4.
    localparam logic signed [57:0] ROUND_HALF = 58'sh8_0000;

    logic signed [15:0] x3_reg;
    logic signed [15:0] y3_reg;
    logic signed [15:0] x4_reg;
    logic signed [15:0] y4_reg;
    logic signed [15:0] x5_reg;
    logic signed [15:0] y5_reg;
    logic signed [15:0] x6_reg;
    logic signed [15:0] y6_reg;

    logic signed [51:0] radx_reg;
    logic signed [51:0] rady_reg;
    logic signed [38:0] du_reg;
    logic signed [38:0] dv_reg;
    logic signed [57:0] pu_reg;
    logic signed [57:0] pv_reg;
    pixel_t             pixel_reg;

    logic signed [52:0] sum_u;
    logic signed [52:0] sum_v;
    logic signed [57:0] rnd_u;
    logic signed [57:0] rnd_v;
    logic signed [38:0] pos_u;
    logic signed [38:0] pos_v;
    logic [20:0]        sat_u;
    logic [20:0]        sat_v;

    // Clamp to the output range; the top bit reports a clamp.
    function automatic logic [20:0] saturate(input logic signed [38:0] v);
        logic [20:0] res;
        begin
            if (v > 39'(OUT_MAX))
            begin
                res = {1'b1, OUT_MAX};
            end
            else if (v < 39'(OUT_MIN))
            begin
                res = {1'b1, OUT_MIN};
            end
            else
            begin
                res = {1'b0, v[19:0]};
            end
            return res;
        end
    endfunction

    // Stages 3 to 6: carry the coordinates alongside the gain.
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            x3_reg <= x;
            y3_reg <= y;
        end
        if (load[3])
        begin
            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
        end
        if (load[4])
        begin
            x5_reg <= x4_reg;
            y5_reg <= y4_reg;
        end
        if (load[5])
        begin
            x6_reg <= x5_reg;
            y6_reg <= y5_reg;
        end
    end

    // Stage 7: radial terms in Q.34.
    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            radx_reg <= x6_reg * gain20;
            rady_reg <= y6_reg * gain20;
        end
    end

    assign sum_u = radx_reg + tan_x;
    assign sum_v = rady_reg + tan_y;

    // Stage 8: distorted coordinate cut to Q.20, rounding down.
    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            du_reg <= sum_u[52:14];
            dv_reg <= sum_v[52:14];
        end
    end

    // Stage 9: scale by the focal lengths into Q.24.
    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            pu_reg <= du_reg * $signed({1'b0, cfg.fx});
            pv_reg <= dv_reg * $signed({1'b0, cfg.fy});
        end
    end

    // Round half up to Q.4, add the principal point and saturate.
    assign rnd_u = pu_reg + ROUND_HALF;
    assign rnd_v = pv_reg + ROUND_HALF;
    assign pos_u = $signed(rnd_u[57:20]) + $signed({1'b0, cfg.cx});
    assign pos_v = $signed(rnd_v[57:20]) + $signed({1'b0, cfg.cy});
    assign sat_u = saturate(pos_u);
    assign sat_v = saturate(pos_v);

    // Stage 10: output register.
    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            pixel_reg.pixel_u <= sat_u[19:0];
            pixel_reg.pixel_v <= sat_v[19:0];
            pixel_reg.clipped <= sat_u[20] | sat_v[20];
        end
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

// File: rtl/lens_distortion_mapper_top.sv
// Lens distortion mapper: a ten-stage pipeline from input word to output word.
// Throughput is one word per cycle while pixel_stall is low.
// Empty stages close up under output back-pressure, so input is taken while a result waits.
// Reset (rst_n, asynchronous, active low) empties the pipeline and restores the registers.
// Depends on ldm_pkg, assert_macros.svh and the ldm_* submodules.
`default_nettype none
`include "assert_macros.svh"

module lens_distortion_mapper_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ldm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             point_valid,
    output logic                             point_stall,
    input  ldm_pkg::point_t                  point,
    output logic                             pixel_valid,
    input  logic                             pixel_stall,
    output ldm_pkg::pixel_t                  pixel
);
    import ldm_pkg::*;

    ldm_cfg_t                cfg;
    stage_en_t               load;
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES-1:0]   valid_next;

    logic [23:0]             r2s;
    logic [32:0]             r2x;
    logic [32:0]             r2y;
    logic signed [31:0]      xy;
    logic signed [15:0]      x;
    logic signed [15:0]      y;
    logic signed [35:0]      gain20;
    logic signed [44:0]      tan_x;
    logic signed [44:0]      tan_y;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !pixel_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next[0] = load[0] ? point_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign point_stall = !load[0];
    assign pixel_valid = valid_reg[NUM_STAGES-1];

    // Configuration registers.
    ldm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages 1 and 2.
    ldm_geom u_geom (
        .clk   (clk),
        .point (point),
        .load  (load),
        .r2s   (r2s),
        .r2x   (r2x),
        .r2y   (r2y),
        .xy    (xy),
        .x     (x),
        .y     (y)
    );

    // Stages 3 to 6, radial gain.
    ldm_radial u_radial (
        .clk    (clk),
        .cfg    (cfg),
        .load   (load),
        .r2s    (r2s),
        .gain20 (gain20)
    );

    // Stages 3 to 7, tangential terms.
    ldm_tangential u_tangential (
        .clk   (clk),
        .cfg   (cfg),
        .load  (load),
        .xy    (xy),
        .r2x   (r2x),
        .r2y   (r2y),
        .tan_x (tan_x),
        .tan_y (tan_y)
    );

    // Stages 3 to 10: coordinate delay, projection and output register.
    ldm_project u_project (
        .clk    (clk),
        .cfg    (cfg),
        .load   (load),
        .x      (x),
        .y      (y),
        .gain20 (gain20),
        .tan_x  (tan_x),
        .tan_y  (tan_y),
        .pixel  (pixel)
    );

    // A completely full pipeline with a waiting result must refuse input.
    `LDM_ASSERT_NOW(a_full_blocks_input, (valid_reg == '1) && pixel_stall, point_stall)

    // An empty entry stage always takes a word.
    `LDM_ASSERT_NOW(a_empty_entry_accepts, !valid_reg[0], !point_stall)

    // The clip flag only accompanies a coordinate sitting on a bound.
    `LDM_ASSERT_NOW(a_clip_on_bound, pixel_valid && pixel.clipped,
        pixel.pixel_u == OUT_MAX || pixel.pixel_u == OUT_MIN ||
        pixel.pixel_v == OUT_MAX || pixel.pixel_v == OUT_MIN)

    // A delivered result followed by a bubble leaves the output empty.
    `LDM_ASSERT_NEXT(a_no_repeat,
        pixel_valid && !pixel_stall && !valid_reg[NUM_STAGES-2], !pixel_valid)

endmodule

`default_nettype wire

// File: test/lens_distortion_checker.sv
`timescale 1ns / 1ps
// Checker for the lens distortion mapper: it follows the register port and both word channels.
// It predicts each pixel word and compares it with the word the block sends; uses ldm_pkg.

module lens_distortion_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ldm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            point_valid,
    input  logic                            point_stall,
    input  ldm_pkg::point_t                 point,
    input  logic                            pixel_valid,
    input  logic                            pixel_stall,
    input  ldm_pkg::pixel_t                 pixel,
    output int                              mismatches,
    output int                              outstanding
);
    import ldm_pkg::*;

    ldm_cfg_t lens_regs;
    pixel_t   pending_pixels[$];
    int       error_count;

    // Normalised offset (Q.34) to a pixel coordinate in Q.4, rounding half up, then centred.
    function automatic longint project_axis(longint d34, longint focal, longint centre);
        longint d20;
        d20 = d34 >>> 14;
        return ((d20 * focal + (64'sd1 <<< 19)) >>> 20) + centre;
    endfunction

    function automatic longint clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = OUT_MAX;
        lo = OUT_MIN;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Full distortion of one point under the given lens registers.
    function automatic pixel_t distort_point(point_t p, ldm_cfg_t c);
        longint x, y, xx, yy, xy, r2, r2s, r4, r6;
        longint k1, k2, k3, p1, p2, fx, fy, cx, cy;
        longint gain, tan_x, tan_y, u, v, u_sat, v_sat;
        pixel_t res;
        x  = $signed(p.x_norm);
        y  = $signed(p.y_norm);
        k1 = $signed(c.k1);
        k2 = $signed(c.k2);
        k3 = $signed(c.k3);
        p1 = $signed(c.p1);
        p2 = $signed(c.p2);
        fx = c.fx;
        fy = c.fy;
        cx = c.cx;
        cy = c.cy;
        xx = x * x;
        yy = y * y;
        xy = x * y;
        r2 = xx + yy;
        // Higher even powers of r come from r2 alone, all in Q.20.
        r2s = r2 >>> 8;
        r4  = (r2s * r2s) >>> 20;
        r6  = (r4 * r2s) >>> 20;
        gain = ((64'sd1 <<< 36) + k1 * r2s + k2 * r4 + k3 * r6) >>> 16;
        // Tangential terms are formed in Q.44 and cut to Q.34.
        tan_x = (2 * p1 * xy + p2 * (r2 + 2 * xx)) >>> 10;
        tan_y = (p1 * (r2 + 2 * yy) + 2 * p2 * xy) >>> 10;
        u = project_axis(x * gain + tan_x, fx, cx);
        v = project_axis(y * gain + tan_y, fy, cy);
        u_sat = clamp_coord(u);
        v_sat = clamp_coord(v);
        res.pixel_u = u_sat[19:0];
        res.pixel_v = v_sat[19:0];
        res.clipped = (u_sat != u) || (v_sat != v);
        return res;
    endfunction

    // Outputs are updated with nonblocking assignments so the stimulus reads settled values.
    always @(posedge clk) begin
        pixel_t want;
        if (!rst_n) begin
            lens_regs    = '0;
            lens_regs.fx = FOCAL_RESET;
            lens_regs.fy = FOCAL_RESET;
            pending_pixels.delete();
            error_count  = 0;
        end else begin
            // Compare a delivered word with the oldest prediction before queueing new ones.
            if (pixel_valid && !pixel_stall) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel word, expected none, got %h", $time, pixel);
                    error_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (pixel.pixel_u !== want.pixel_u) begin
                        $display("%0t: pixel_u expected %0d, got %0d",
                                 $time, want.pixel_u, pixel.pixel_u);
                        error_count++;
                    end
                    if (pixel.pixel_v !== want.pixel_v) begin
                        $display("%0t: pixel_v expected %0d, got %0d",
                                 $time, want.pixel_v, pixel.pixel_v);
                        error_count++;
                    end
                    if (pixel.clipped !== want.clipped) begin
                        $display("%0t: clipped expected %0d, got %0d",
                                 $time, want.clipped, pixel.clipped);
                        error_count++;
                    end
                end
            end
            // A newly accepted point joins the tail of the prediction queue.
            if (point_valid && !point_stall)
                pending_pixels.insert(pending_pixels.size(), distort_point(point, lens_regs));
            // Follow register writes; bits above each register's width are dropped.
            if (cfg_write) begin
                case (cfg_index)
                    REG_RADIAL_K1:     lens_regs.k1 = cfg_data[19:0];
                    REG_RADIAL_K2:     lens_regs.k2 = cfg_data[19:0];
                    REG_RADIAL_K3:     lens_regs.k3 = cfg_data[19:0];
                    REG_TANGENTIAL_P1: lens_regs.p1 = cfg_data[19:0];
                    REG_TANGENTIAL_P2: lens_regs.p2 = cfg_data[19:0];
                    REG_FOCAL_X:       lens_regs.fx = cfg_data[17:0];
                    REG_FOCAL_Y:       lens_regs.fy = cfg_data[17:0];
                    REG_CENTER_PACKED:
                    begin
                        lens_regs.cx = cfg_data[15:0];
                        lens_regs.cy = cfg_data[31:16];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        mismatches  <= error_count;
        outstanding <= pending_pixels.size();
    end

endmodule

// File: test/tb_lens_distortion_mapper_top.sv
`timescale 1ns / 1ps
// Testbench top for the lens distortion mapper: clock, reset, lens settings and point words.
// Uses ldm_pkg, the block itself and lens_distortion_checker, which counts the mismatches.

module tb_lens_distortion_mapper_top;
    import ldm_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int POINTS_PER_LENS = 56;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   point_valid;
    logic                   point_stall;
    point_t                 point;
    logic                   pixel_valid;
    logic                   pixel_stall = 1'b0;
    pixel_t                 pixel;
    int                     mismatches;
    int                     outstanding;
    int                     send_idle_pct;
    int                     stall_pct;
    int                     cycle_count;
    logic [CFG_DATA_W-1:0]  lens_regs [8];

    // Corner points: opposite and equal extremes, the origin, one axis at a time, one LSB.
    logic [31:0] corner_words [8] = '{32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_7FFF,
                                      32'h8000_8000, 32'h0000_0000, 32'h4000_0000,
                                      32'h0000_C000, 32'h0001_FFFF};

    lens_distortion_mapper_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

    lens_distortion_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Random back-pressure on the pixel side.
    always @(posedge clk)
    begin
        pixel_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one point word after a random gap and hold it until it is taken.
    task automatic send_point(input point_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
    endtask

    // Stop offering words and wait until every predicted pixel word has come back.
    task automatic settle();
        point_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all eight registers once the block has gone idle.
    task automatic load_lens();
        settle();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= lens_regs[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic fill_lens(input logic [31:0] coef, input logic [31:0] focal,
                             input logic [31:0] centre);
        lens_regs[REG_RADIAL_K1]     = coef;
        lens_regs[REG_RADIAL_K2]     = coef;
        lens_regs[REG_RADIAL_K3]     = coef;
        lens_regs[REG_TANGENTIAL_P1] = coef;
        lens_regs[REG_TANGENTIAL_P2] = coef;
        lens_regs[REG_FOCAL_X]       = focal;
        lens_regs[REG_FOCAL_Y]       = focal;
        lens_regs[REG_CENTER_PACKED] = centre;
    endtask

    // A plausible camera has small coefficients and a focal length of 300 to 3000 pixels;
    // a wild one takes every register at random. Bits above each width stay random.
    task automatic pick_lens(input bit wild);
        for (int i = 0; i < 8; i++)
            lens_regs[i] = $urandom;
        if (!wild)
        begin
            for (int i = REG_RADIAL_K1; i <= REG_TANGENTIAL_P2; i++)
                lens_regs[i][19:0] = 20'($urandom_range(65536) - 32768);
            lens_regs[REG_FOCAL_X][17:0] = 18'($urandom_range(48000, 4800));
            lens_regs[REG_FOCAL_Y][17:0] = 18'($urandom_range(48000, 4800));
        end
    endtask

    // Mostly points inside the unit square, sometimes anywhere in the Q2.14 range.
    function automatic point_t random_point();
        point_t p;
        p = $urandom;
        if ($urandom_range(3) != 0)
        begin
            p.x_norm = 16'($urandom_range(32768) - 16384);
            p.y_norm = 16'($urandom_range(32768) - 16384);
        end
        return p;
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_RADIAL_K1;
        cfg_data      = '0;
        point_valid   = 1'b0;
        point         = '0;
        send_idle_pct = 15;
        stall_pct     = 52;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner points with the registers as reset left them.
        for (int i = 0; i < 8; i++)
            send_point(point_t'(corner_words[i]));
        // Every register at its top value: most outputs saturate.
        fill_lens(32'h0007_FFFF, 32'h0003_FFFF, 32'hFFFF_FFFF);
        load_lens();
        for (int i = 0; i < 8; i++)
            send_point(point_t'(corner_words[i]));
        // Most negative coefficients with zero focal length and centre.
        fill_lens(32'hFFF8_0000, 32'h0000_0000, 32'h0000_0000);
        load_lens();
        for (int i = 0; i < 4; i++)
            send_point(point_t'(corner_words[i]));
        // No distortion at the widest focal length: both extremes land just inside the range.
        fill_lens(32'h0000_0000, 32'h0003_FFFF, 32'h0000_0000);
        load_lens();
        for (int i = 0; i < 4; i++)
            send_point(point_t'(corner_words[i]));

        // Random lenses and points under each idling pattern.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    stall_pct    <= 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct    <= 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
            endcase
            for (int lens = 0; lens < 3; lens++)
            begin
                pick_lens(lens == 2);
                load_lens();
                repeat (POINTS_PER_LENS)
                    send_point(random_point());
            end
        end

        settle();
        repeat (2 * NUM_STAGES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
